/* rtl/core/rnps_pkg.sv */
// Package: shared types and constants for the nearest-point-to-ray store.
`default_nettype none
package rnps_pkg;
  localparam int CAPACITY_DEF = 1024;
  localparam int CW = 24;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DELETED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic           mode;
    logic [CW-1:0]  px;
    logic [CW-1:0]  py;
    logic [CW-1:0]  pz;
    logic [CW-1:0]  ox;
    logic [CW-1:0]  oy;
    logic [CW-1:0]  oz;
    logic [CW-1:0]  dx;
    logic [CW-1:0]  dy;
    logic [CW-1:0]  dz;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_INS, BK_SCAN, BK_DRAIN, BK_FETCH, BK_MOVE, BK_DONE
  } bk_state_t;
endpackage
`default_nettype wire

/* rtl/core/ray_nearest_point_store.sv */
// Top level of the nearest-point-to-ray store.
// Usage: in_* carries one transaction per item; mode 0 inserts point_x/y/z
// at the end of the table, mode 1 removes the stored point nearest the ray
// (least |dir x (p - origin)|^2, lowest index on ties) by moving the last
// entry into its slot. Each item yields exactly one out_* transaction with
// status, slot, removed point and count after the item.
// The single memory read port feeds the metric pipeline one point per cycle
// while a delete scans the table. Items are processed one at a time; the
// next starts the cycle after the result is taken. A two-entry queue takes
// in new items while the back end works.
// Reset clears the point count; table contents need no clearing.
// While out_stall is high the result holds and the back end waits; in_stall
// rises once the queue is full.
`default_nettype none
module ray_nearest_point_store #(
  parameter int CAPACITY = rnps_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic signed [23:0] in_point_x,
  input  wire logic signed [23:0] in_point_y,
  input  wire logic signed [23:0] in_point_z,
  input  wire logic signed [23:0] in_ray_origin_x,
  input  wire logic signed [23:0] in_ray_origin_y,
  input  wire logic signed [23:0] in_ray_origin_z,
  input  wire logic signed [23:0] in_ray_dir_x,
  input  wire logic signed [23:0] in_ray_dir_y,
  input  wire logic signed [23:0] in_ray_dir_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [9:0]              out_slot,
  output logic signed [23:0]      out_removed_x,
  output logic signed [23:0]      out_removed_y,
  output logic signed [23:0]      out_removed_z,
  output logic [10:0]             out_count_after
);
  rnps_pkg::cmd_t in_cmd, q_cmd;
  logic q_valid, q_take;

  assign in_cmd = '{mode: in_mode, px: in_point_x, py: in_point_y, pz: in_point_z,
                    ox: in_ray_origin_x, oy: in_ray_origin_y, oz: in_ray_origin_z,
                    dx: in_ray_dir_x, dy: in_ray_dir_y, dz: in_ray_dir_z};

  rnps_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd,
    .q_valid, .q_cmd, .q_take
  );

  rnps_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take,
    .out_valid, .out_stall, .out_status, .out_slot,
    .out_removed_x, .out_removed_y, .out_removed_z, .out_count_after
  );

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count_after <= 11'(CAPACITY))
    else $error("count exceeds capacity");
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rnps_pkg::ST_FULL) |-> out_count_after == 11'(CAPACITY))
    else $error("full flagged below capacity");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rnps_pkg::ST_EMPTY) |-> out_count_after == '0)
    else $error("empty flag with points");
endmodule
`default_nettype wire

/* rtl/core/rnps_front.sv */
// Front end: two-entry command queue between input channel and back end.
`default_nettype none
module rnps_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rnps_pkg::cmd_t in_cmd,
  output logic                q_valid,
  output rnps_pkg::cmd_t      q_cmd,
  input  wire logic           q_take
);
  rnps_pkg::cmd_t buf_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_cmd    = buf_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= in_cmd;
  end
endmodule
`default_nettype wire

/* rtl/core/rnps_back.sv */
// Back end: point memory, ray metric pipeline, scan and swap-remove sequencer.
`default_nettype none
module rnps_back #(
  parameter int CAPACITY = rnps_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire rnps_pkg::cmd_t q_cmd,
  output logic                q_take,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          out_status,
  output logic [9:0]          out_slot,
  output logic signed [23:0]  out_removed_x,
  output logic signed [23:0]  out_removed_y,
  output logic signed [23:0]  out_removed_z,
  output logic [10:0]         out_count_after
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int CW = rnps_pkg::CW;
  localparam int LAT = 8;

  rnps_pkg::bk_state_t st_r, st_nxt;
  logic [CW-1:0] mem_x [CAPACITY];
  logic [CW-1:0] mem_y [CAPACITY];
  logic [CW-1:0] mem_z [CAPACITY];

  logic [NW-1:0] count_r;
  logic [NW-1:0] iss_r;
  rnps_pkg::cmd_t cmd_r;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rdx_r, rdy_r, rdz_r;
  logic [LAT-1:0] vpipe_r;
  logic [AW-1:0]  ipipe_r [LAT];
  logic [AW-1:0]  best_r;
  logic [97:0]    bestm_r;
  logic           have_r;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [CW-1:0]  wx, wy, wz;
  logic           fetch_first_r;

  // metric pipeline stage registers
  logic signed [CW:0]   vx_r, vy_r, vz_r;
  logic signed [49:0]   p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [50:0]   c0_r, c1_r, c2_r;
  logic [48:0]          a0_r, a1_r, a2_r;
  logic [47:0]          hh0_r, hh1_r, hh2_r;
  logic [48:0]          hl0_r, hl1_r, hl2_r;
  logic [49:0]          ll0_r, ll1_r, ll2_r;
  logic [97:0]          s0_r, s1_r, s2_r;
  logic [97:0]          m_r;

  logic [1:0]        ost_r;
  logic [9:0]        oslot_r;
  logic [10:0]       ocnt_r;
  logic              ov_r;

  logic signed [CW-1:0] sdx, sdy, sdz;
  assign sdx = cmd_r.dx;
  assign sdy = cmd_r.dy;
  assign sdz = cmd_r.dz;

  // square of a 49-bit magnitude from its high and low partial products
  function automatic logic [97:0] sq_join(logic [47:0] hh, logic [48:0] hl, logic [49:0] ll);
    return (98'(hh) << 50) + (98'(hl) << 26) + 98'(ll);
  endfunction

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rnps_pkg::BK_IDLE: if (q_valid && !ov_r) begin
        if (!q_cmd.mode)          st_nxt = rnps_pkg::BK_INS;
        else if (count_r == '0)   st_nxt = rnps_pkg::BK_DONE;
        else                      st_nxt = rnps_pkg::BK_SCAN;
      end
      rnps_pkg::BK_INS:   st_nxt = rnps_pkg::BK_DONE;
      rnps_pkg::BK_SCAN:  if (iss_r == count_r - 1'b1) st_nxt = rnps_pkg::BK_DRAIN;
      rnps_pkg::BK_DRAIN: if (vpipe_r == '0) st_nxt = rnps_pkg::BK_FETCH;
      rnps_pkg::BK_FETCH: if (!fetch_first_r) st_nxt = rnps_pkg::BK_MOVE;
      rnps_pkg::BK_MOVE:  st_nxt = rnps_pkg::BK_DONE;
      rnps_pkg::BK_DONE:  st_nxt = rnps_pkg::BK_IDLE;
      default:            st_nxt = rnps_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_take  = 1'b0;
    rd_addr = iss_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wx = cmd_r.px;
    wy = cmd_r.py;
    wz = cmd_r.pz;
    case (st_r)
      rnps_pkg::BK_IDLE:  q_take = q_valid && !ov_r;
      rnps_pkg::BK_INS:   wr_en = (count_r < NW'(CAPACITY));
      rnps_pkg::BK_FETCH: rd_addr = fetch_first_r ? best_r : AW'(count_r - 1'b1);
      rnps_pkg::BK_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = best_r;
        wx = rdx_r;
        wy = rdy_r;
        wz = rdz_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rdx_r <= mem_x[rd_addr];
    rdy_r <= mem_y[rd_addr];
    rdz_r <= mem_z[rd_addr];
    if (wr_en) begin
      mem_x[wr_addr] <= wx;
      mem_y[wr_addr] <= wy;
      mem_z[wr_addr] <= wz;
    end
  end

  // metric datapath: diff, products, cross, magnitude, partial squares, join, sum
  always_ff @(posedge clk) begin
    vx_r <= $signed(rdx_r) - $signed(cmd_r.ox);
    vy_r <= $signed(rdy_r) - $signed(cmd_r.oy);
    vz_r <= $signed(rdz_r) - $signed(cmd_r.oz);
    p1_r <= sdy * vz_r;
    p2_r <= sdz * vy_r;
    p3_r <= sdz * vx_r;
    p4_r <= sdx * vz_r;
    p5_r <= sdx * vy_r;
    p6_r <= sdy * vx_r;
    c0_r <= p1_r - p2_r;
    c1_r <= p3_r - p4_r;
    c2_r <= p5_r - p6_r;
    a0_r <= c0_r[50] ? 49'(-c0_r) : 49'(c0_r);
    a1_r <= c1_r[50] ? 49'(-c1_r) : 49'(c1_r);
    a2_r <= c2_r[50] ? 49'(-c2_r) : 49'(c2_r);
    hh0_r <= a0_r[48:25] * a0_r[48:25];
    hh1_r <= a1_r[48:25] * a1_r[48:25];
    hh2_r <= a2_r[48:25] * a2_r[48:25];
    hl0_r <= a0_r[48:25] * a0_r[24:0];
    hl1_r <= a1_r[48:25] * a1_r[24:0];
    hl2_r <= a2_r[48:25] * a2_r[24:0];
    ll0_r <= a0_r[24:0] * a0_r[24:0];
    ll1_r <= a1_r[24:0] * a1_r[24:0];
    ll2_r <= a2_r[24:0] * a2_r[24:0];
    s0_r <= sq_join(hh0_r, hl0_r, ll0_r);
    s1_r <= sq_join(hh1_r, hl1_r, ll1_r);
    s2_r <= sq_join(hh2_r, hl2_r, ll2_r);
    m_r  <= s0_r + s1_r + s2_r;
  end

  always_ff @(posedge clk) begin
    ipipe_r[0] <= iss_r[AW-1:0];
    for (int k = 1; k < LAT; k++) ipipe_r[k] <= ipipe_r[k-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= rnps_pkg::BK_IDLE;
      count_r       <= '0;
      iss_r         <= '0;
      vpipe_r       <= '0;
      have_r        <= 1'b0;
      ov_r          <= 1'b0;
      fetch_first_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      vpipe_r <= {vpipe_r[LAT-2:0], st_r == rnps_pkg::BK_SCAN};
      if (out_valid && !out_stall) ov_r <= 1'b0;
      case (st_r)
        rnps_pkg::BK_IDLE: begin
          iss_r  <= '0;
          have_r <= 1'b0;
          fetch_first_r <= 1'b1;
          if (q_take) cmd_r <= q_cmd;
        end
        rnps_pkg::BK_SCAN: iss_r <= iss_r + 1'b1;
        rnps_pkg::BK_FETCH: fetch_first_r <= 1'b0;
        default: ;
      endcase
      // strict less keeps lowest index on ties
      if (vpipe_r[LAT-1] && (!have_r || m_r < bestm_r)) begin
        have_r  <= 1'b1;
        bestm_r <= m_r;
        best_r  <= ipipe_r[LAT-1];
      end
      if (st_r == rnps_pkg::BK_DONE) begin
        ov_r <= 1'b1;
        oslot_r <= '0;
        if (!cmd_r.mode) begin
          if (count_r < NW'(CAPACITY)) begin
            ost_r   <= rnps_pkg::ST_INSERTED;
            oslot_r <= 10'(count_r);
            count_r <= count_r + 1'b1;
            ocnt_r  <= 11'(count_r + 1'b1);
          end else begin
            ost_r  <= rnps_pkg::ST_FULL;
            ocnt_r <= 11'(count_r);
          end
        end else if (count_r == '0) begin
          ost_r  <= rnps_pkg::ST_EMPTY;
          ocnt_r <= '0;
        end else begin
          ost_r   <= rnps_pkg::ST_DELETED;
          oslot_r <= 10'(best_r);
          count_r <= count_r - 1'b1;
          ocnt_r  <= 11'(count_r - 1'b1);
        end
      end
    end
  end

  // hold the best entry, read in the first fetch cycle
  logic [CW-1:0] remx_r, remy_r, remz_r;
  always_ff @(posedge clk) begin
    if (st_r == rnps_pkg::BK_FETCH && !fetch_first_r) begin
      remx_r <= rdx_r;
      remy_r <= rdy_r;
      remz_r <= rdz_r;
    end
  end

  // fetch order: best entry first, then last; MOVE writes the last into the best slot
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_slot        = oslot_r;
  assign out_removed_x   = (ost_r == rnps_pkg::ST_DELETED) ? remx_r : '0;
  assign out_removed_y   = (ost_r == rnps_pkg::ST_DELETED) ? remy_r : '0;
  assign out_removed_z   = (ost_r == rnps_pkg::ST_DELETED) ? remz_r : '0;
  assign out_count_after = ocnt_r;
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for ray_nearest_point_store: random and directed insert/delete traffic.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = rnps_pkg::CAPACITY_DEF;
  localparam int CMD_W = $bits(rnps_pkg::cmd_t);

  typedef struct {
    rnps_pkg::status_t  st;
    logic [9:0]         slot;
    logic signed [23:0] rx, ry, rz;
    logic [10:0]        cnt;
  } removal_t;

  logic clk, rst_n;
  logic in_valid, in_stall, in_mode;
  logic signed [23:0] in_point_x, in_point_y, in_point_z;
  logic signed [23:0] in_ray_origin_x, in_ray_origin_y, in_ray_origin_z;
  logic signed [23:0] in_ray_dir_x, in_ray_dir_y, in_ray_dir_z;
  logic out_valid, out_stall;
  logic [1:0] out_status;
  logic [9:0] out_slot;
  logic signed [23:0] out_removed_x, out_removed_y, out_removed_z;
  logic [10:0] out_count_after;

  ray_nearest_point_store dut (.*);

  // predictor copy of the point table
  logic signed [23:0] pts_x [DEPTH];
  logic signed [23:0] pts_y [DEPTH];
  logic signed [23:0] pts_z [DEPTH];
  int unsigned pts_count;
  removal_t pending_q[$];
  int errors, mismatches;
  int send_idle_pct, recv_stall_pct;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [99:0] ray_dist2(int idx, rnps_pkg::cmd_t c);
    logic signed [63:0] vx, vy, vz, ox, oy, oz, dx, dy, dz, c0, c1, c2;
    logic [63:0] m;
    logic [99:0] acc, mm;
    ox = $signed(c.ox); oy = $signed(c.oy); oz = $signed(c.oz);
    dx = $signed(c.dx); dy = $signed(c.dy); dz = $signed(c.dz);
    vx = pts_x[idx]; vy = pts_y[idx]; vz = pts_z[idx];
    vx = vx - ox; vy = vy - oy; vz = vz - oz;
    c0 = dy * vz - dz * vy;
    c1 = dz * vx - dx * vz;
    c2 = dx * vy - dy * vx;
    acc = '0;
    m = (c0 < 0) ? -c0 : c0; mm = m; acc = acc + mm * mm;
    m = (c1 < 0) ? -c1 : c1; mm = m; acc = acc + mm * mm;
    m = (c2 < 0) ? -c2 : c2; mm = m; acc = acc + mm * mm;
    return acc;
  endfunction

  function automatic removal_t predict_item(rnps_pkg::cmd_t c);
    removal_t r;
    logic [99:0] best_d, d;
    int best, last;
    r.st = rnps_pkg::ST_INSERTED; r.slot = '0; r.rx = '0; r.ry = '0; r.rz = '0;
    if (!c.mode) begin
      if (pts_count >= DEPTH) begin
        r.st = rnps_pkg::ST_FULL;
      end else begin
        pts_x[pts_count] = c.px; pts_y[pts_count] = c.py; pts_z[pts_count] = c.pz;
        r.slot = pts_count[9:0];
        pts_count++;
      end
    end else if (pts_count == 0) begin
      r.st = rnps_pkg::ST_EMPTY;
    end else begin
      best = 0;
      best_d = ray_dist2(0, c);
      for (int i = 1; i < pts_count; i++) begin
        d = ray_dist2(i, c);
        if (d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      r.st = rnps_pkg::ST_DELETED;
      r.slot = best[9:0];
      r.rx = pts_x[best]; r.ry = pts_y[best]; r.rz = pts_z[best];
      last = pts_count - 1;
      pts_x[best] = pts_x[last]; pts_y[best] = pts_y[last]; pts_z[best] = pts_z[last];
      pts_count = last;
    end
    r.cnt = pts_count[10:0];
    return r;
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h000000;
      3: return 24'hffffff;
      4: return 24'($urandom_range(0, 15)) - 24'd8;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic rnps_pkg::cmd_t make_insert(logic [23:0] x, logic [23:0] y,
                                                 logic [23:0] z);
    rnps_pkg::cmd_t c;
    c = rnps_pkg::cmd_t'(CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom}));
    c.mode = 1'b0; c.px = x; c.py = y; c.pz = z;
    return c;
  endfunction

  function automatic rnps_pkg::cmd_t make_delete(logic [23:0] ox, logic [23:0] oy,
                                                 logic [23:0] oz, logic [23:0] dx,
                                                 logic [23:0] dy, logic [23:0] dz);
    rnps_pkg::cmd_t c;
    c = rnps_pkg::cmd_t'(CMD_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom}));
    c.mode = 1'b1;
    c.ox = ox; c.oy = oy; c.oz = oz; c.dx = dx; c.dy = dy; c.dz = dz;
    return c;
  endfunction

  // valid stays high between back-to-back transactions; drop it only for a gap
  task automatic send_item(rnps_pkg::cmd_t c);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= c.mode;
    in_point_x      <= c.px;  in_point_y      <= c.py;  in_point_z      <= c.pz;
    in_ray_origin_x <= c.ox;  in_ray_origin_y <= c.oy;  in_ray_origin_z <= c.oz;
    in_ray_dir_x    <= c.dx;  in_ray_dir_y    <= c.dy;  in_ray_dir_z    <= c.dz;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(predict_item(c));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected transaction: status %0d", out_status);
      end else begin
        removal_t e;
        e = pending_q.pop_front();
        if (out_status !== e.st || out_slot !== e.slot || out_removed_x !== e.rx ||
            out_removed_y !== e.ry || out_removed_z !== e.rz ||
            out_count_after !== e.cnt) begin
          errors++;
          if (mismatches++ < 10) begin
            $display("mismatch: exp st %0d slot %0d pt %h %h %h cnt %0d",
                     e.st, e.slot, e.rx, e.ry, e.rz, e.cnt);
            $display("          got st %0d slot %0d pt %h %h %h cnt %0d",
                     out_status, out_slot, out_removed_x, out_removed_y,
                     out_removed_z, out_count_after);
          end
        end
      end
    end
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic test_directed();
    send_item(make_delete(rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord()));
    send_item(make_insert(24'h800000, 24'h800000, 24'h800000));
    send_item(make_insert(24'h7fffff, 24'h7fffff, 24'h7fffff));
    send_item(make_insert(24'h000000, 24'hffffff, 24'h800000));
    send_item(make_insert(24'h7fffff, 24'h000000, 24'h800000));
    // extreme origin and direction: widest metric
    send_item(make_delete(24'h800000, 24'h800000, 24'h800000,
                          24'h7fffff, 24'h800000, 24'h7fffff));
    send_item(make_delete(24'h7fffff, 24'h000000, 24'h800000,
                          24'h800000, 24'h800000, 24'h800000));
    // zero direction removes index 0
    send_item(make_delete(rand_coord(), rand_coord(), rand_coord(),
                          24'd0, 24'd0, 24'd0));
    send_item(make_delete(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd256));
    send_item(make_delete(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd256));
    // duplicates on the ray: lowest index wins
    for (int i = 0; i < 4; i++) send_item(make_insert(24'd100, 24'd100, 24'(i * 50)));
    send_item(make_insert(24'd5, 24'd7, 24'd9));
    send_item(make_delete(24'd100, 24'd100, 24'd0, 24'd0, 24'd0, 24'd1));
    send_item(make_delete(24'd100, 24'd100, 24'd0, 24'd0, 24'd0, 24'h800000));
    for (int i = 0; i < 4; i++)
      send_item(make_delete(rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord()));
  endtask

  task automatic test_random(int n);
    rnps_pkg::cmd_t c;
    int k;
    for (int i = 0; i < n; i++) begin
      if (pts_count == 0 || (pts_count < 48 && $urandom_range(0, 99) < 55)) begin
        if (pts_count > 0 && $urandom_range(0, 4) == 0) begin
          k = $urandom_range(0, pts_count - 1);
          c = make_insert(pts_x[k], pts_y[k], pts_z[k]);
        end else begin
          c = make_insert(rand_coord(), rand_coord(), rand_coord());
        end
        if ($urandom_range(0, 30) == 0) c.mode = 1'b1;
      end else begin
        c = make_delete(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(0, 9) == 0) begin
          c.dx = '0; c.dy = '0; c.dz = '0;
        end
      end
      send_item(c);
    end
  endtask

  // grow the table past the random phases and scan the larger table
  task automatic test_large();
    repeat (30) send_item(make_insert(rand_coord(), rand_coord(), rand_coord()));
    send_item(make_delete(rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord()));
    send_item(make_delete(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
    send_item(make_insert(24'h7fffff, 24'h800000, 24'h000000));
    send_item(make_insert(24'h800000, 24'h7fffff, 24'hffffff));
    send_item(make_delete(24'h800000, 24'h7fffff, 24'h000000,
                          24'h7fffff, 24'h800000, 24'h7fffff));
  endtask

  initial begin
    errors = 0; mismatches = 0; pts_count = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_mode = 1'b0; out_stall = 1'b0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0;
    in_ray_origin_x = '0; in_ray_origin_y = '0; in_ray_origin_z = '0;
    in_ray_dir_x = '0; in_ray_dir_y = '0; in_ray_dir_z = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(130);
    send_idle_pct = 54; test_random(130);
    send_idle_pct = 0; recv_stall_pct = 54; test_random(130);
    send_idle_pct = 23; recv_stall_pct = 23; test_random(130);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_large();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
rtl/core/rnps_pkg.sv
rtl/core/rnps_front.sv
rtl/core/rnps_back.sv
rtl/core/ray_nearest_point_store.sv
tb/sv/tb_top.sv
